@@ sv/packed_palette_index_unpacker_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packed palette index unpacker.
// Both macros expect signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef PACKED_PALETTE_INDEX_UNPACKER_UNIT_ASSERT_SVH
`define PACKED_PALETTE_INDEX_UNPACKER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPIU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppiu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PPIU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppiu assertion failed");

`endif

@@ sv/ppiu_pkg.sv @@
// ----------------------------------------------------------------------------
// ppiu_pkg
// Shared widths, codes, microcode table and helpers of the palette unpacker.
// ----------------------------------------------------------------------------
package ppiu_pkg;

  localparam int WORD_BITS    = 64;
  localparam int IDX_MAX_BITS = 12;
  localparam int BUF_BITS     = WORD_BITS + IDX_MAX_BITS;
  localparam int NB_W         = $clog2(BUF_BITS + 1);
  localparam int WID_W        = 4;
  localparam int MIN_WIDTH    = 2;
  localparam int SIZE_W       = 13;
  localparam int CX_W         = 12;
  localparam int POS_W        = 26;
  localparam int MAT_W        = 16;
  localparam int PALETTE_MAX  = 4096;
  localparam int AXIS_MAX     = 4096;
  localparam int PAL_DEPTH    = 1 << IDX_MAX_BITS;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;
  localparam int IN_TDATA_W   = 96;
  localparam int OUT_TDATA_W  = 96;

  localparam logic [SIZE_W-1:0] PAL_SAT  = SIZE_W'(PALETTE_MAX);
  localparam logic [SIZE_W-1:0] AXIS_SAT = SIZE_W'(AXIS_MAX);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_COUNT = 3'd0,
    REG_SIZE_X        = 3'd1,
    REG_SIZE_Y        = 3'd2,
    REG_SIZE_Z        = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5,
    REG_ORIGIN_Z      = 3'd6
  } cfg_reg_t;

  // Microcode step addresses.
  typedef logic [1:0] step_t;
  localparam step_t S_IDLE  = 2'd0;
  localparam step_t S_RUN   = 2'd1;
  localparam step_t S_DRAIN = 2'd2;
  localparam step_t S_FLUSH = 2'd3;

  typedef enum logic [1:0] {
    OP_ACCEPT = 2'd0,
    OP_INDEX  = 2'd1,
    OP_NONE   = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    C_WORD_GO  = 2'd0,
    C_RUN_END  = 2'd1,
    C_NO_STALL = 2'd2,
    C_FLUSHED  = 2'd3
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    op_t   op;
    cond_t cond;
    step_t target;
  } ucw_t;

  typedef struct packed {
    logic in_ready;
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic word_go;
    logic run_end;
    logic no_stall;
    logic flushed;
  } status_t;

  // Control store. Each step holds until its condition is met, then jumps.
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    unique case (s)
      S_IDLE:  w = '{in_ready: 1'b1, op: OP_ACCEPT, cond: C_WORD_GO,  target: S_RUN};
      S_RUN:   w = '{in_ready: 1'b0, op: OP_INDEX,  cond: C_RUN_END,  target: S_DRAIN};
      S_DRAIN: w = '{in_ready: 1'b0, op: OP_NONE,   cond: C_NO_STALL, target: S_FLUSH};
      S_FLUSH: w = '{in_ready: 1'b0, op: OP_FLUSH,  cond: C_FLUSHED,  target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [SIZE_W-1:0] saturate(logic [SIZE_W-1:0] v,
                                                 logic [SIZE_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // Smallest width of at least two bits whose code space covers the palette.
  function automatic logic [WID_W-1:0] index_width(logic [SIZE_W-1:0] pc);
    logic [WID_W-1:0] w;
    w = WID_W'(MIN_WIDTH);
    for (int k = MIN_WIDTH; k < IDX_MAX_BITS; k++) begin
      if (int'(pc) > (1 << k)) begin
        w = WID_W'(k + 1);
      end
    end
    return w;
  endfunction

endpackage

@@ sv/ppiu_seq.sv @@
// ----------------------------------------------------------------------------
// ppiu_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module ppiu_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  ppiu_pkg::status_t status,
  output ppiu_pkg::ctrl_t   ctrl
);

  ppiu_pkg::step_t step_r;
  ppiu_pkg::step_t step_nxt;
  ppiu_pkg::ucw_t  word;
  logic            cond_met;

  always_comb begin
    word = ppiu_pkg::ucode(step_r);
    unique case (word.cond)
      ppiu_pkg::C_WORD_GO:  cond_met = status.word_go;
      ppiu_pkg::C_RUN_END:  cond_met = status.run_end;
      ppiu_pkg::C_NO_STALL: cond_met = status.no_stall;
      ppiu_pkg::C_FLUSHED:  cond_met = status.flushed;
      default:              cond_met = 1'b0;
    endcase
    step_nxt      = cond_met ? word.target : step_r;
    ctrl.in_ready = word.in_ready;
    ctrl.op       = word.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ppiu_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ sv/ppiu_walk.sv @@
// ----------------------------------------------------------------------------
// ppiu_walk
// Voxel walk counters (x fastest, then z, then y) and coordinate adders.
// ----------------------------------------------------------------------------
module ppiu_walk (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                advance,
  input  logic        [ppiu_pkg::SIZE_W-1:0]  size_x,
  input  logic        [ppiu_pkg::SIZE_W-1:0]  size_y,
  input  logic        [ppiu_pkg::SIZE_W-1:0]  size_z,
  input  logic signed [ppiu_pkg::POS_W-1:0]   origin_x,
  input  logic signed [ppiu_pkg::POS_W-1:0]   origin_y,
  input  logic signed [ppiu_pkg::POS_W-1:0]   origin_z,
  output logic                                done,
  output logic signed [ppiu_pkg::POS_W-1:0]   pos_x,
  output logic signed [ppiu_pkg::POS_W-1:0]   pos_y,
  output logic signed [ppiu_pkg::POS_W-1:0]   pos_z
);

  logic [ppiu_pkg::CX_W-1:0]   cx_r, cx_nxt;
  logic [ppiu_pkg::CX_W-1:0]   cz_r, cz_nxt;
  logic [ppiu_pkg::SIZE_W-1:0] cy_r, cy_nxt;
  logic [ppiu_pkg::SIZE_W-1:0] cx_inc, cz_inc;

  always_comb begin
    cx_inc = ppiu_pkg::SIZE_W'(cx_r) + 1'b1;
    cz_inc = ppiu_pkg::SIZE_W'(cz_r) + 1'b1;
    cx_nxt = cx_r;
    cz_nxt = cz_r;
    cy_nxt = cy_r;
    if (restart) begin
      cx_nxt = '0;
      cz_nxt = '0;
      cy_nxt = '0;
    end else if (advance) begin
      if (cx_inc >= size_x) begin
        cx_nxt = '0;
        if (cz_inc >= size_z) begin
          cz_nxt = '0;
          cy_nxt = cy_r + 1'b1;
        end else begin
          cz_nxt = cz_inc[ppiu_pkg::CX_W-1:0];
        end
      end else begin
        cx_nxt = cx_inc[ppiu_pkg::CX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cz_r <= '0;
      cy_r <= '0;
    end else begin
      cx_r <= cx_nxt;
      cz_r <= cz_nxt;
      cy_r <= cy_nxt;
    end
  end

  assign done = (size_x == '0) || (size_y == '0) || (size_z == '0) || (cy_r >= size_y);

  assign pos_x = origin_x + $signed(ppiu_pkg::POS_W'(cx_r));
  assign pos_y = origin_y + $signed(ppiu_pkg::POS_W'(cy_r));
  assign pos_z = origin_z + $signed(ppiu_pkg::POS_W'(cz_r));

endmodule

@@ sv/ppiu_unpack.sv @@
// ----------------------------------------------------------------------------
// ppiu_unpack
// Bit buffer, index extraction, remap memory, result hold and output register.
// ----------------------------------------------------------------------------
`include "packed_palette_index_unpacker_unit_assert.svh"

module ppiu_unpack (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ppiu_pkg::ctrl_t                      ctrl,
  output ppiu_pkg::status_t                    status,
  input  logic                                 restart,
  input  logic        [ppiu_pkg::WID_W-1:0]    width,
  input  logic        [ppiu_pkg::SIZE_W-1:0]   pal_count,
  input  logic                                 done,
  output logic                                 walk_step,
  input  logic signed [ppiu_pkg::POS_W-1:0]    walk_x,
  input  logic signed [ppiu_pkg::POS_W-1:0]    walk_y,
  input  logic signed [ppiu_pkg::POS_W-1:0]    walk_z,
  input  logic                                 in_tvalid,
  input  logic                                 req_type,
  input  logic        [ppiu_pkg::IDX_MAX_BITS-1:0] entry_index,
  input  logic        [ppiu_pkg::MAT_W-1:0]    entry_material,
  input  logic        [ppiu_pkg::WORD_BITS-1:0] data_word,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic signed [ppiu_pkg::POS_W-1:0]    pos_x,
  output logic signed [ppiu_pkg::POS_W-1:0]    pos_y,
  output logic signed [ppiu_pkg::POS_W-1:0]    pos_z,
  output logic        [ppiu_pkg::MAT_W-1:0]    material,
  output logic                                 last_of_word
);

  logic [ppiu_pkg::BUF_BITS-1:0]     buf_r, buf_nxt;
  logic [ppiu_pkg::NB_W-1:0]         nb_r, nb_nxt;
  logic [ppiu_pkg::IDX_MAX_BITS-1:0] mask, v;
  logic                              accept, wr_en, word_go, has_idx, go_a;
  logic                              hit, stall, out_free, b_take, b_push, flush_out;
  logic                              out_load, left_ok;

  logic                              s1_valid_r;
  logic signed [ppiu_pkg::POS_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [ppiu_pkg::MAT_W-1:0]        rd_data_r;

  logic                              pend_valid_r;
  logic signed [ppiu_pkg::POS_W-1:0] pend_x_r, pend_y_r, pend_z_r;
  logic [ppiu_pkg::MAT_W-1:0]        pend_mat_r;

  logic                              out_valid_r;
  logic signed [ppiu_pkg::POS_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [ppiu_pkg::MAT_W-1:0]        out_mat_r;
  logic                              out_last_r;

  logic [ppiu_pkg::MAT_W-1:0]        remap_mem [ppiu_pkg::PAL_DEPTH];

  always_comb begin
    accept  = in_tvalid && ctrl.in_ready && (ctrl.op == ppiu_pkg::OP_ACCEPT);
    wr_en   = accept && !req_type;
    word_go = accept && req_type && !done;

    mask    = ppiu_pkg::IDX_MAX_BITS'((13'd1 << width) - 13'd1);
    v       = buf_r[ppiu_pkg::IDX_MAX_BITS-1:0] & mask;
    has_idx = (nb_r >= ppiu_pkg::NB_W'(width)) && !done;
    left_ok = nb_r < ppiu_pkg::NB_W'(width);

    out_free  = !out_valid_r || out_tready;
    hit       = s1_valid_r && (rd_data_r != '0);
    stall     = hit && pend_valid_r && !out_free;
    go_a      = (ctrl.op == ppiu_pkg::OP_INDEX) && has_idx && !stall;
    b_take    = hit && !stall;
    b_push    = b_take && pend_valid_r;
    flush_out = (ctrl.op == ppiu_pkg::OP_FLUSH) && pend_valid_r && out_free;
    out_load  = b_push || flush_out;

    walk_step = go_a;

    status.word_go  = word_go;
    status.run_end  = !has_idx && !stall;
    status.no_stall = !stall;
    status.flushed  = !pend_valid_r || out_free;

    buf_nxt = buf_r;
    nb_nxt  = nb_r;
    if (restart) begin
      buf_nxt = '0;
      nb_nxt  = '0;
    end else if (word_go) begin
      buf_nxt = buf_r | (ppiu_pkg::BUF_BITS'(data_word) << nb_r);
      nb_nxt  = nb_r + ppiu_pkg::NB_W'(ppiu_pkg::WORD_BITS);
    end else if (go_a) begin
      buf_nxt = buf_r >> width;
      nb_nxt  = nb_r - ppiu_pkg::NB_W'(width);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r        <= '0;
      nb_r         <= '0;
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      buf_r <= buf_nxt;
      nb_r  <= nb_nxt;
      if (!stall) begin
        s1_valid_r <= go_a && (ppiu_pkg::SIZE_W'(v) < pal_count);
      end
      if (b_take) begin
        pend_valid_r <= 1'b1;
      end else if (flush_out) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (go_a) begin
      s1_x_r <= walk_x;
      s1_y_r <= walk_y;
      s1_z_r <= walk_z;
    end
    if (b_take) begin
      pend_x_r   <= s1_x_r;
      pend_y_r   <= s1_y_r;
      pend_z_r   <= s1_z_r;
      pend_mat_r <= rd_data_r;
    end
    if (out_load) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_z_r    <= pend_z_r;
      out_mat_r  <= pend_mat_r;
      out_last_r <= flush_out;
    end
  end

  // Remap table: written by load items, read one index per cycle when not stalled.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      remap_mem[entry_index] <= entry_material;
    end
    if (go_a) begin
      rd_data_r <= remap_mem[v];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign pos_x        = out_x_r;
  assign pos_y        = out_y_r;
  assign pos_z        = out_z_r;
  assign material     = out_mat_r;
  assign last_of_word = out_last_r;

  `PPIU_ASSERT_NOW(a_rw_exclusive, wr_en, !go_a)
  `PPIU_ASSERT_NOW(a_flush_drained, ctrl.op == ppiu_pkg::OP_FLUSH, !s1_valid_r)
  `PPIU_ASSERT_NOW(a_leftover_short, ctrl.op == ppiu_pkg::OP_ACCEPT && !done, left_ok)
  `PPIU_ASSERT_NXT(a_stall_holds, stall, s1_valid_r)

endmodule

@@ sv/packed_palette_index_unpacker_unit.sv @@
// A remap load is written into the remap table as it is accepted; a data word is
// taken into the bit buffer, then its indices are unpacked at one per cycle by
// the index step while the result channel does not stall. A new item is taken
// only once the previous word has been unpacked, drained and flushed.
// Reset: synchronous active-low; counters, leftover bits and handshakes clear.
// ----------------------------------------------------------------------------
// packed_palette_index_unpacker_unit
// Unpacks bit-packed palette indices, remaps them and emits voxel results.
// ----------------------------------------------------------------------------
module packed_palette_index_unpacker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,  // req_type
  // [11:0] entry_index, [27:12] entry_material, [91:28] data_word, [95:92] zero
  input  logic [ppiu_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic                                out_tlast,  // last_of_word
  // [25:0] pos_x, [51:26] pos_y, [77:52] pos_z, [93:78] material, [95:94] zero
  output logic [ppiu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppiu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppiu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration is held in its effective form: sizes and palette count are
  // saturated on write, and the index width is worked out once per palette count write.
  logic        [ppiu_pkg::SIZE_W-1:0] pal_r, size_x_r, size_y_r, size_z_r;
  logic        [ppiu_pkg::WID_W-1:0]  width_r;
  logic signed [ppiu_pkg::POS_W-1:0]  org_x_r, org_y_r, org_z_r;
  logic                               cfg_we, restart;
  logic        [ppiu_pkg::SIZE_W-1:0] cfg_sz, cfg_pal;

  ppiu_pkg::ctrl_t   ctrl;
  ppiu_pkg::status_t status;

  logic                              done, walk_step;
  logic signed [ppiu_pkg::POS_W-1:0] walk_x, walk_y, walk_z;
  logic signed [ppiu_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
  logic        [ppiu_pkg::MAT_W-1:0] material;

  // Writes are only expected while the block is idle, so the port is always open.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_sz    = ppiu_pkg::saturate(cfg_data[ppiu_pkg::SIZE_W-1:0], ppiu_pkg::AXIS_SAT);
  assign cfg_pal   = ppiu_pkg::saturate(cfg_data[ppiu_pkg::SIZE_W-1:0], ppiu_pkg::PAL_SAT);

  // Any write to a known register restarts the walk and drops leftover bits;
  // writes to unused indexes are ignored entirely.
  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (ppiu_pkg::cfg_reg_t'(cfg_index))
        ppiu_pkg::REG_PALETTE_COUNT,
        ppiu_pkg::REG_SIZE_X,
        ppiu_pkg::REG_SIZE_Y,
        ppiu_pkg::REG_SIZE_Z,
        ppiu_pkg::REG_ORIGIN_X,
        ppiu_pkg::REG_ORIGIN_Y,
        ppiu_pkg::REG_ORIGIN_Z: restart = 1'b1;
        default:                restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r    <= ppiu_pkg::SIZE_W'(1);
      width_r  <= ppiu_pkg::WID_W'(ppiu_pkg::MIN_WIDTH);
      size_x_r <= ppiu_pkg::SIZE_W'(1);
      size_y_r <= ppiu_pkg::SIZE_W'(1);
      size_z_r <= ppiu_pkg::SIZE_W'(1);
      org_x_r  <= '0;
      org_y_r  <= '0;
      org_z_r  <= '0;
    end else if (cfg_we) begin
      case (ppiu_pkg::cfg_reg_t'(cfg_index))
        ppiu_pkg::REG_PALETTE_COUNT: begin
          pal_r   <= cfg_pal;
          width_r <= ppiu_pkg::index_width(cfg_pal);
        end
        ppiu_pkg::REG_SIZE_X:   size_x_r <= cfg_sz;
        ppiu_pkg::REG_SIZE_Y:   size_y_r <= cfg_sz;
        ppiu_pkg::REG_SIZE_Z:   size_z_r <= cfg_sz;
        ppiu_pkg::REG_ORIGIN_X: org_x_r  <= $signed(cfg_data);
        ppiu_pkg::REG_ORIGIN_Y: org_y_r  <= $signed(cfg_data);
        ppiu_pkg::REG_ORIGIN_Z: org_z_r  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // The sequencer steps through accept, index run, pipeline drain and final
  // flush; the datapath reports back the conditions its jumps test.
  ppiu_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  ppiu_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .advance  (walk_step),
    .size_x   (size_x_r),
    .size_y   (size_y_r),
    .size_z   (size_z_r),
    .origin_x (org_x_r),
    .origin_y (org_y_r),
    .origin_z (org_z_r),
    .done     (done),
    .pos_x    (walk_x),
    .pos_y    (walk_y),
    .pos_z    (walk_z)
  );

  // Each hit is parked in a hold register until the next hit or the end of the
  // word, so the last result of a word can be marked before it leaves.
  ppiu_unpack u_unpack (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .status         (status),
    .restart        (restart),
    .width          (width_r),
    .pal_count      (pal_r),
    .done           (done),
    .walk_step      (walk_step),
    .walk_x         (walk_x),
    .walk_y         (walk_y),
    .walk_z         (walk_z),
    .in_tvalid      (in_tvalid),
    .req_type       (in_tuser),
    .entry_index    (in_tdata[11:0]),
    .entry_material (in_tdata[27:12]),
    .data_word      (in_tdata[91:28]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .material       (material),
    .last_of_word   (out_tlast)
  );

  assign in_tready = ctrl.in_ready;
  assign out_tdata = {2'b00, material, pos_z, pos_y, pos_x};

endmodule
